### src/bnd_pkg.sv
package bnd_pkg;

  // Largest image the frame store holds.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W   = 9;
  localparam int PASS_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(256);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(256);
  localparam logic [PASS_W-1:0] PASS_RESET   = PASS_W'(10);
  localparam logic [DIM_W-1:0]  WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [10:0]      SUM_SEVEN_WHITE = 11'd1785;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 neighbourhood, indexed [row][column], row 0 is the row above.
  typedef pix_t [2:0][2:0] window_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_PASSES = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_index_t;

endpackage

### src/binary_neighborhood_denoise.sv
// Binary neighbourhood denoiser with an on-chip frame store of 256 x 256 pixels.
// Input words arrive on in_valid/in_ready and carry an action, a coordinate and
// a pixel; every input word yields exactly one output word on out_valid/out_ready
// carrying pixel_out and status. A write updates one pixel and answers in the
// cycle after acceptance; a read inside the image answers after S_RDWAIT, which
// waits for the registered frame data. A run word sweeps the frame pass_total
// times, all interior pixels of a pass updated from the image as it stood before
// that pass, and answers when the last pass ends. For each column of a row the
// run reads the frame twice (S_MID, S_DN) and shifts the 3x3 window (S_SHIFT),
// writes each interior pixel back in S_WRITE, and on the first row of a pass
// reads the untouched top row once more per column in S_UP. The block takes one
// word at a time and is not ready during a run or a read. A write or read outside
// the configured image is ignored and reported by status. Reset restores the
// configuration defaults (256 x 256, ten passes) and empties the output
// register; the frame store keeps no reset value. If the receiver
// stalls, the answer waits in the output register and the next input word is
// held off until that register is free or being emptied in the same cycle.
module binary_neighborhood_denoise (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [bnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bnd_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [bnd_pkg::ROW_W-1:0]     row,
  input  logic [bnd_pkg::COL_W-1:0]     column,
  input  logic [bnd_pkg::PIX_W-1:0]     pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bnd_pkg::PIX_W-1:0]     pixel_out,
  output logic                          status
);
  import bnd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_MID,
    S_DN,
    S_UP,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [PASS_W-1:0] pass_total;
  logic [DIM_W-1:0]  eff_width;
  logic [DIM_W-1:0]  eff_height;

  // Scan counters.
  logic [ROW_W-1:0]  scan_row;
  logic [COL_W-1:0]  scan_col;
  logic [PASS_W-1:0] pass_index;

  // Column being gathered and the sliding window.
  pix_t    up_col;
  pix_t    mid_col;
  pix_t    dn_col;
  window_t win;
  pix_t    rule_pixel;

  logic accept;
  logic outside;
  logic top_row;
  logic row_end;
  logic last_row;
  logic tiny;
  action_t act;

  // Frame store and line buffer ports.
  logic              frame_we;
  logic [ADDR_W-1:0] frame_waddr;
  pix_t              frame_wdata;
  logic [ADDR_W-1:0] frame_raddr;
  pix_t              frame_rdata;
  logic              line_we;
  pix_t              line_rdata;

  assign act        = action_t'(action);
  assign eff_width  = (image_width  > WIDTH_LIMIT)  ? WIDTH_LIMIT  : image_width;
  assign eff_height = (image_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : image_height;
  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept     = in_valid && in_ready;
  assign outside    = ({1'b0, row} >= eff_height) || ({1'b0, column} >= eff_width);
  assign tiny       = (eff_width < DIM_W'(3)) || (eff_height < DIM_W'(3)) ||
                      (pass_total == '0);
  assign top_row    = scan_row == ROW_W'(1);
  assign row_end    = {1'b0, scan_col} == eff_width - DIM_W'(1);
  assign last_row   = {1'b0, scan_row} + DIM_W'(2) == eff_height;

  // Frame store: host access while idle, scan reads in S_MID, S_DN and S_UP and scan writes in S_WRITE.
  always_comb begin
    case (state)
      S_MID:   frame_raddr = {scan_row, scan_col};
      S_DN:    frame_raddr = {scan_row + ROW_W'(1), scan_col};
      S_UP:    frame_raddr = {ROW_W'(0), scan_col};
      default: frame_raddr = {row, column};
    endcase
  end

  assign frame_we    = (accept && act == ACT_WRITE && !outside) || (state == S_WRITE);
  assign frame_waddr = (state == S_WRITE) ? {scan_row, scan_col - COL_W'(1)} : {row, column};
  assign frame_wdata = (state == S_WRITE) ? rule_pixel : pixel_in;

  // The line buffer holds the old values of the row above; each column is read
  // before it is overwritten with the old value of the current row.
  assign line_we = state == S_DN;

  bnd_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (FRAME_DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  bnd_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (scan_col),
    .wdata (frame_rdata),
    .raddr (scan_col),
    .rdata (line_rdata)
  );

  bnd_rule u_rule (
    .win   (win),
    .pixel (rule_pixel)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      pass_total   <= PASS_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_WIDTH:  image_width  <= cfg_data;
        CFG_HEIGHT: image_height <= cfg_data;
        CFG_PASSES: pass_total   <= cfg_data[PASS_W-1:0];
        default:    ;
      endcase
    end
  end

  // Sequencer, scan counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_row   <= '0;
      scan_col   <= '0;
      pass_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (act)
              ACT_WRITE: begin
                out_valid <= 1'b1;
                pixel_out <= PIX_BLACK;
                status    <= outside;
              end
              ACT_READ: begin
                if (outside) begin
                  out_valid <= 1'b1;
                  pixel_out <= PIX_BLACK;
                  status    <= 1'b1;
                end else begin
                  state <= S_RDWAIT;
                end
              end
              ACT_RUN: begin
                if (tiny) begin
                  state <= S_DONE;
                end else begin
                  scan_row   <= ROW_W'(1);
                  scan_col   <= '0;
                  pass_index <= '0;
                  state      <= S_MID;
                end
              end
              default: begin
                out_valid <= 1'b1;
                pixel_out <= PIX_BLACK;
                status    <= 1'b0;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          out_valid <= 1'b1;
          pixel_out <= frame_rdata;
          status    <= 1'b0;
          state     <= S_IDLE;
        end
        S_MID: begin
          state <= S_DN;
        end
        S_DN: begin
          mid_col <= frame_rdata;
          up_col  <= line_rdata;
          state   <= top_row ? S_UP : S_SHIFT;
        end
        S_UP: begin
          dn_col <= frame_rdata;
          state  <= S_SHIFT;
        end
        S_SHIFT: begin
          // On the first row the top neighbours come from the frame itself.
          win[0][0] <= win[0][1];
          win[0][1] <= win[0][2];
          win[0][2] <= top_row ? frame_rdata : up_col;
          win[1][0] <= win[1][1];
          win[1][1] <= win[1][2];
          win[1][2] <= mid_col;
          win[2][0] <= win[2][1];
          win[2][1] <= win[2][2];
          win[2][2] <= top_row ? dn_col : frame_rdata;
          if (scan_col >= COL_W'(2)) begin
            state <= S_WRITE;
          end else begin
            scan_col <= scan_col + COL_W'(1);
            state    <= S_MID;
          end
        end
        S_WRITE: begin
          if (!row_end) begin
            scan_col <= scan_col + COL_W'(1);
            state    <= S_MID;
          end else begin
            scan_col <= '0;
            if (!last_row) begin
              scan_row <= scan_row + ROW_W'(1);
              state    <= S_MID;
            end else if (pass_index != pass_total - PASS_W'(1)) begin
              pass_index <= pass_index + PASS_W'(1);
              scan_row   <= ROW_W'(1);
              state      <= S_MID;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          scan_row   <= '0;
          scan_col   <= '0;
          pass_index <= '0;
          out_valid  <= 1'b1;
          pixel_out  <= PIX_BLACK;
          status     <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/bnd_ram.sv
module bnd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bnd_rule.sv
module bnd_rule (
  input  bnd_pkg::window_t win,
  output bnd_pkg::pix_t    pixel
);
  import bnd_pkg::*;

  pix_t        n0, n1, n2, n3, n4, n5, n6, n7, px;
  logic [9:0]  orth_sum;
  logic [10:0] ring_sum;
  logic        top_set, right_set, bottom_set, left_set;

  assign n0 = win[0][0];
  assign n1 = win[0][1];
  assign n2 = win[0][2];
  assign n3 = win[1][0];
  assign px = win[1][1];
  assign n4 = win[1][2];
  assign n5 = win[2][0];
  assign n6 = win[2][1];
  assign n7 = win[2][2];

  assign orth_sum = 10'(n1) + 10'(n3) + 10'(n4) + 10'(n6);
  assign ring_sum = 11'(n0) + 11'(n1) + 11'(n2) + 11'(n3)
                  + 11'(n4) + 11'(n5) + 11'(n6) + 11'(n7);

  // Half-plane patterns: all five neighbours on one side are white.
  assign top_set    = (n0 & n1 & n2 & n3 & n4) == PIX_WHITE;
  assign right_set  = (n1 & n2 & n4 & n6 & n7) == PIX_WHITE;
  assign bottom_set = (n3 & n4 & n5 & n6 & n7) == PIX_WHITE;
  assign left_set   = (n0 & n1 & n3 & n5 & n6) == PIX_WHITE;

  always_comb begin
    pixel = px;
    if (px == PIX_WHITE) begin
      if (orth_sum <= 10'd1) begin
        pixel = PIX_BLACK;
      end
    end else if (px == PIX_BLACK) begin
      if (ring_sum == SUM_SEVEN_WHITE || top_set || right_set || bottom_set || left_set) begin
        pixel = PIX_WHITE;
      end
    end
  end

endmodule
